// File: rtl/hgtc_pkg.sv
// Package for the hand gesture template classifier.
// Holds payload structs, gesture codes, register indexes and the fingerprint table.
// No dependencies.
package hgtc_pkg;

    localparam int Fingers    = 5;
    localparam int Prints     = 8;
    localparam int RatioW     = 12;
    localparam int ScoreW     = 13;
    localparam int CfgDataW   = 60;
    localparam int CfgIdxW    = 3;
    localparam int DivSteps   = 13;
    localparam logic [ScoreW-1:0] FullQ12 = 13'd4096;
    localparam logic [RatioW:0]   CalMinSpan = 13'd52;

    typedef enum logic [3:0] {
        G_NONE = 4'd0, G_OPEN = 4'd1, G_FIST = 4'd2, G_THUMBSUP = 4'd3,
        G_PEACE = 4'd4, G_GUNS = 4'd5, G_GUNSHOT = 4'd6, G_CALLME = 4'd7,
        G_ROCKON = 4'd8, G_THUMBOVER = 4'd9
    } t_gesture;

    typedef enum logic [CfgIdxW-1:0] {
        R_CALIBRATED = 3'd0, R_FIST = 3'd1, R_OPEN = 3'd2, R_PIVOT = 3'd3,
        R_MIN_CONF = 3'd4, R_MIN_MARGIN = 3'd5, R_THUMB_THR = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [11:0]        thumb_ratio;
        logic [11:0]        index_ratio;
        logic [11:0]        middle_ratio;
        logic [11:0]        ring_ratio;
        logic [11:0]        little_ratio;
        logic signed [15:0] thumb_alignment;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  gesture;
        logic [12:0] confidence;
    } t_out_item;

    // Per-lane setup handed down the divider pipeline.
    typedef struct packed {
        logic              use_cal;
        logic              zero;
        logic [RatioW:0]   num;
        logic [RatioW:0]   span;
    } t_lane_ctl;

    // Fingerprint masks, thumb in bit 0. ext: 1 extended, care: 1 used.
    function automatic logic [Fingers-1:0] print_ext(input int k);
        case (k)
            0: print_ext = 5'b11111;
            1: print_ext = 5'b00000;
            2: print_ext = 5'b00001;
            3: print_ext = 5'b00110;
            4: print_ext = 5'b00011;
            5: print_ext = 5'b00010;
            6: print_ext = 5'b10001;
            default: print_ext = 5'b10010;
        endcase
    endfunction

    function automatic logic [Fingers-1:0] print_care(input int k);
        print_care = (k == 7) ? 5'b11110 : 5'b11111;
    endfunction

endpackage

// File: rtl/hand_gesture_template_classifier_unit.sv
// Hand gesture template classifier: accepts one item per cycle while no result
// waits stalled at the output; each item passes through the five parallel
// 13-step divider lanes and then the two-stage score merge. A stalled
// waiting result freezes the whole pipeline. Depends on hgtc_pkg, hgtc_lane and hgtc_merge.
module hand_gesture_template_classifier_unit import hgtc_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  t_in_item            i_item,
    output logic                o_valid,
    input  logic                i_stall,
    output t_out_item           o_item,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_idx,
    input  logic [CfgDataW-1:0] i_cfg_data
);
    localparam int Lat = DivSteps + 4;

    logic               r_cal;
    logic [59:0]        r_fist, r_open;
    logic [11:0]        r_pivot;
    logic [12:0]        r_min_conf, r_min_margin;
    logic signed [15:0] r_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal <= 1'b0; r_fist <= '0; r_open <= '0; r_pivot <= 12'd614;
            r_min_conf <= 13'd2048; r_min_margin <= 13'd410; r_thr <= 16'sd8192;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                R_CALIBRATED: r_cal        <= i_cfg_data[0];
                R_FIST:       r_fist       <= i_cfg_data[59:0];
                R_OPEN:       r_open       <= i_cfg_data[59:0];
                R_PIVOT:      r_pivot      <= i_cfg_data[11:0];
                R_MIN_CONF:   r_min_conf   <= i_cfg_data[12:0];
                R_MIN_MARGIN: r_min_margin <= i_cfg_data[12:0];
                R_THUMB_THR:  r_thr        <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // All stages advance together unless a finished result is held by the
    // receiver; then every stage keeps its item and the input is stalled.
    logic [Lat-1:0] r_vld;
    logic           adv;
    assign adv     = !r_vld[Lat-1] || !i_stall;
    assign o_stall = !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[Lat-2:0], i_valid};
        end
    end

    logic [Fingers-1:0][11:0] ratios;
    assign ratios = {i_item.little_ratio, i_item.ring_ratio, i_item.middle_ratio,
                     i_item.index_ratio, i_item.thumb_ratio};

    logic [Fingers-1:0][ScoreW-1:0] norm;
    for (genvar i = 0; i < Fingers; i++) begin : g_lane
        hgtc_lane u_lane (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(adv), .i_ratio(ratios[i]),
            .i_calibrated(r_cal), .i_fist(r_fist[12*i +: 12]),
            .i_open(r_open[12*i +: 12]), .i_pivot(r_pivot), .o_norm(norm[i])
        );
    end

    logic [DivSteps+1:0][15:0] r_align;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_align <= {r_align[DivSteps:0], i_item.thumb_alignment};
        end
    end

    hgtc_merge u_merge (
        .i_clk(i_clk), .i_en(adv), .i_norm(norm), .i_align(r_align[DivSteps+1]),
        .i_min_conf(r_min_conf), .i_min_margin(r_min_margin), .i_thumb_thr(r_thr),
        .o_item(o_item)
    );

    assign o_valid = r_vld[Lat-1];

    a_reset_clears_valid: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid);
    a_stalled_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_item));
    a_stall_only_when_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall);
    a_result_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_item.gesture <= G_THUMBOVER && o_item.confidence <= FullQ12);
endmodule

// File: rtl/hgtc_lane.sv
// One finger lane: normalizes a raw ratio to a Q1.12 match strength (4096 is 1.0).
// Pipelined restoring divider, one quotient bit per stage; uses hgtc_pkg.
module hgtc_lane import hgtc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic [RatioW-1:0] i_ratio,
    input  logic              i_calibrated,
    input  logic [RatioW-1:0] i_fist,
    input  logic [RatioW-1:0] i_open,
    input  logic [RatioW-1:0] i_pivot,
    output logic [ScoreW-1:0] o_norm
);
    // Stage 0: choose the path and set up the divide, or finish the ramp.
    t_lane_ctl   n_ctl;
    logic [12:0] n_ramp;
    logic signed [13:0] diff_ramp;
    logic signed [19:0] t_val;
    logic [13:0] ramp_y;
    logic [30:0] ramp_prod;
    logic signed [13:0] span_s, num_s;

    always_comb begin
        span_s  = $signed({2'b00, i_open}) - $signed({2'b00, i_fist});
        num_s   = $signed({2'b00, i_ratio}) - $signed({2'b00, i_fist});
        n_ctl.use_cal = i_calibrated && (span_s >= $signed({1'b0, CalMinSpan}));
        n_ctl.zero    = (num_s <= 14'sd0);
        n_ctl.num     = num_s[RatioW:0];
        n_ctl.span    = span_s[RatioW:0];
        diff_ramp = $signed({2'b00, i_ratio}) - $signed({2'b00, i_pivot});
        t_val     = 20'(diff_ramp) * 20'sd25 + 20'sd3072;
        // For 0 < t < 6144 the rounded 2t/3 equals floor((2t + 1) / 3), which a
        // reciprocal multiply by ceil(2^17 / 3) gives exactly in this range.
        ramp_y    = {t_val[12:0], 1'b1};
        ramp_prod = 31'(ramp_y) * 31'd43691;
        if (t_val <= 20'sd0) begin
            n_ramp = '0;
        end else if (t_val >= 20'sd6144) begin
            n_ramp = FullQ12;
        end else begin
            n_ramp = ramp_prod[29:17];
        end
    end

    // Divider: (num*4096 + span/2) / span, quotient capped at 13 bits.
    // The quotient exceeds 4096 when the ratio lies above the open value; saturation clamps it.
    logic [DivSteps:0][RatioW:0]   r_span;
    logic [DivSteps:0][25:0]       r_rem;
    logic [DivSteps:0][DivSteps:0] r_quo;
    logic [DivSteps:0]             r_use;
    logic [DivSteps:0]             r_zero;
    logic [DivSteps:0][12:0]       r_ramp;
    logic [DivSteps:0]             r_ovf;

    // Quotient bit b = 13..1 is decided at stage 13 - b; bit 13 set means overflow.
    logic [DivSteps-1:0]       div_ge;
    logic [DivSteps-1:0][25:0] div_rem;
    always_comb begin
        for (int s = 0; s < DivSteps; s++) begin
            div_ge[s]  = (39'(r_rem[s]) >= (39'(r_span[s]) << (DivSteps - s)));
            div_rem[s] = div_ge[s] ?
                         26'(39'(r_rem[s]) - (39'(r_span[s]) << (DivSteps - s))) : r_rem[s];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_span[0] <= n_ctl.span;
            r_rem[0]  <= {1'b0, n_ctl.num, 12'd0} + 26'(n_ctl.span[RatioW:1]);
            r_quo[0]  <= '0;
            r_use[0]  <= n_ctl.use_cal;
            r_zero[0] <= n_ctl.zero;
            r_ramp[0] <= n_ramp;
            r_ovf[0]  <= 1'b0;
            for (int s = 0; s < DivSteps; s++) begin
                r_span[s+1] <= r_span[s];
                r_rem[s+1]  <= div_rem[s];
                r_quo[s+1]  <= r_quo[s] |
                               (div_ge[s] ? ((DivSteps+1)'(1) << (DivSteps - s)) : '0);
                r_ovf[s+1]  <= r_ovf[s] | (div_ge[s] && s == 0);
                r_use[s+1]  <= r_use[s];
                r_zero[s+1] <= r_zero[s];
                r_ramp[s+1] <= r_ramp[s];
            end
        end
    end

    logic [DivSteps:0] q_fin;
    logic [12:0]       n_norm;
    logic [12:0]       r_norm;
    always_comb begin
        q_fin = r_quo[DivSteps] |
                (DivSteps+1)'(39'(r_rem[DivSteps]) >= 39'(r_span[DivSteps]));
        if (!r_use[DivSteps]) begin
            n_norm = r_ramp[DivSteps];
        end else if (r_zero[DivSteps]) begin
            n_norm = '0;
        end else if (r_ovf[DivSteps] || q_fin > 14'(FullQ12)) begin
            n_norm = FullQ12;
        end else begin
            n_norm = q_fin[12:0];
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_norm <= n_norm;
        end
    end
    assign o_norm = r_norm;

    logic unused;
    assign unused = i_rst_n;
endmodule

// File: rtl/hgtc_merge.sv
// Merging stage: scores the eight fingerprints and keeps top and runner-up.
// Two registered stages; uses hgtc_pkg.
module hgtc_merge import hgtc_pkg::*; (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [Fingers-1:0][ScoreW-1:0] i_norm,
    input  logic signed [15:0]             i_align,
    input  logic [ScoreW-1:0]              i_min_conf,
    input  logic [ScoreW-1:0]              i_min_margin,
    input  logic signed [15:0]             i_thumb_thr,
    output t_out_item                      o_item
);
    logic [Prints-1:0][ScoreW-1:0] n_score, r_score;
    logic                          r_flat;
    logic [Fingers-1:0]            p_ext, p_care;
    always_comb begin
        p_ext  = '0;
        p_care = '0;
        for (int k = 0; k < Prints; k++) begin
            p_ext  = print_ext(k);
            p_care = print_care(k);
            n_score[k] = FullQ12;
            for (int i = 0; i < Fingers; i++) begin
                if (p_care[i]) begin
                    if (p_ext[i]) begin
                        if (i_norm[i] < n_score[k]) n_score[k] = i_norm[i];
                    end else if (FullQ12 - i_norm[i] < n_score[k]) begin
                        n_score[k] = FullQ12 - i_norm[i];
                    end
                end
            end
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_score <= n_score;
            r_flat  <= i_align < i_thumb_thr;
        end
    end

    logic [ScoreW-1:0] top, sec;
    logic [3:0]        ges;
    t_out_item         n_item, r_item;
    always_comb begin
        top = '0;
        sec = '0;
        ges = G_NONE;
        for (int k = 0; k < Prints; k++) begin
            if (r_score[k] > top) begin
                sec = top;
                top = r_score[k];
                ges = 4'(k + 1);
            end else if (r_score[k] > sec) begin
                sec = r_score[k];
            end
        end
        if (top < i_min_conf || (top - sec) < i_min_margin) ges = G_NONE;
        if (ges == G_THUMBSUP && r_flat) ges = G_THUMBOVER;
        n_item.gesture    = ges;
        n_item.confidence = top;
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end
    assign o_item = r_item;
endmodule
